FILE: hdl/ltc_pkg.sv
// Package for the Latin to Cyrillic transliterator.
// It holds the state codes, the result kinds, the letter tables and the step types.
// It has no dependencies. All modules use it; the interfaces do not.
`timescale 1ns / 1ps

package ltc_pkg;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_Y    = 4'd1;
    localparam logic [3:0] ST_Z    = 4'd2;
    localparam logic [3:0] ST_S    = 4'd3;
    localparam logic [3:0] ST_K    = 4'd4;
    localparam logic [3:0] ST_C    = 4'd5;
    localparam logic [3:0] ST_T    = 4'd6;
    localparam logic [3:0] ST_SH   = 4'd7;
    localparam logic [3:0] ST_SHC  = 4'd8;
    localparam logic [3:0] ST_ERR  = 4'd9;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_EOL  = 2'd2;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DQUOTE = 7'h22;
    localparam logic [6:0] CH_APOS  = 7'h27;
    localparam logic [6:0] CH_AT    = 7'h40;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_C     = 7'h63;
    localparam logic [6:0] CH_E     = 7'h65;
    localparam logic [6:0] CH_H     = 7'h68;
    localparam logic [6:0] CH_K     = 7'h6B;
    localparam logic [6:0] CH_O     = 7'h6F;
    localparam logic [6:0] CH_S     = 7'h73;
    localparam logic [6:0] CH_T     = 7'h74;
    localparam logic [6:0] CH_U     = 7'h75;
    localparam logic [6:0] CH_Y     = 7'h79;
    localparam logic [6:0] CH_Z     = 7'h7A;

    localparam logic [10:0] CP_SPACE = 11'h020;
    localparam logic [10:0] CP_HARD  = 11'h44A;
    localparam logic [10:0] CP_SOFT  = 11'h44C;
    localparam logic [10:0] CP_CHE   = 11'h447;
    localparam logic [10:0] CP_SHA   = 11'h448;
    localparam logic [10:0] CP_SHCHA = 11'h449;
    localparam logic [10:0] CP_YA    = 11'h44F;
    localparam logic [10:0] CP_YE    = 11'h435;
    localparam logic [10:0] CP_YO    = 11'h451;
    localparam logic [10:0] CP_YU    = 11'h44E;
    localparam logic [10:0] CP_ZHE   = 11'h436;
    localparam logic [10:0] CP_KHA   = 11'h445;
    localparam logic [10:0] CP_TSE   = 11'h446;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] cp;
    } res_t;

    typedef struct packed {
        res_t [2:0]  res;
        logic [1:0]  cnt;
        logic [3:0]  next_state;
    } step_t;

    typedef struct packed {
        logic        emit;
        logic [10:0] cp;
        logic [3:0]  next_state;
    } plain_t;

    // single letters a..v; zero where the letter is not a plain table entry
    function automatic logic [10:0] letter_cp(input logic [6:0] c);
        logic [10:0] cp;
        case (c)
            7'h61:   cp = 11'h430;
            7'h62:   cp = 11'h431;
            7'h64:   cp = 11'h434;
            7'h65:   cp = 11'h44D;
            7'h66:   cp = 11'h444;
            7'h67:   cp = 11'h433;
            7'h69:   cp = 11'h438;
            7'h6A:   cp = 11'h439;
            7'h6C:   cp = 11'h43B;
            7'h6D:   cp = 11'h43C;
            7'h6E:   cp = 11'h43D;
            7'h6F:   cp = 11'h43E;
            7'h70:   cp = 11'h43F;
            7'h72:   cp = 11'h440;
            7'h75:   cp = 11'h443;
            7'h76:   cp = 11'h432;
            default: cp = 11'h000;
        endcase
        return cp;
    endfunction

    // letter held back in each prefix state
    function automatic logic [10:0] pending_cp(input logic [3:0] st);
        logic [10:0] cp;
        case (st)
            ST_Y:    cp = 11'h44B;
            ST_Z:    cp = 11'h437;
            ST_S:    cp = 11'h441;
            ST_K:    cp = 11'h43A;
            ST_T:    cp = 11'h442;
            ST_SH:   cp = 11'h448;
            default: cp = 11'h000;
        endcase
        return cp;
    endfunction

    // character with nothing pending
    function automatic plain_t plain(input logic [6:0] c);
        plain_t p;
        p.emit       = 1'b0;
        p.cp         = 11'h000;
        p.next_state = ST_IDLE;
        case (c)
            CH_C:      p.next_state = ST_C;
            CH_K:      p.next_state = ST_K;
            CH_S:      p.next_state = ST_S;
            CH_T:      p.next_state = ST_T;
            CH_Y:      p.next_state = ST_Y;
            CH_Z:      p.next_state = ST_Z;
            CH_SPACE:  begin p.emit = 1'b1; p.cp = CP_SPACE; end
            CH_DQUOTE: begin p.emit = 1'b1; p.cp = CP_HARD; end
            CH_APOS:   begin p.emit = 1'b1; p.cp = CP_SOFT; end
            CH_AT:     p.next_state = ST_IDLE;
            default:
            begin
                if (letter_cp(c) != 11'h000)
                begin
                    p.emit = 1'b1;
                    p.cp   = letter_cp(c);
                end
                else
                begin
                    p.next_state = ST_ERR;
                end
            end
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/ltc_in_if.sv
// Input channel: one ASCII character per item with valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface ltc_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: hdl/ltc_out_if.sv
// Output channel: one Cyrillic code point or marker per item, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface ltc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [10:0] code_point;
    logic        run_end;

    modport source (output valid, output kind, output code_point, output run_end,
                    input ready);
    modport sink   (input valid, input kind, input code_point, input run_end,
                    output ready);
endinterface

FILE: hdl/ltc_step.sv
// Next-state and result logic for one input character.
// Depends on ltc_pkg.
`timescale 1ns / 1ps

module ltc_step (
    input  logic [3:0]     state,
    input  logic [6:0]     char_code,
    input  logic           last_char,
    output ltc_pkg::step_t step
);

    always_comb
    begin
        logic [4:0]        cand_v;
        logic [4:0][1:0]   cand_k;
        logic [4:0][10:0]  cand_cp;
        logic [3:0]        s1;
        logic [2:0]        n;
        ltc_pkg::plain_t   p;

        cand_v  = '0;
        cand_k  = '0;
        cand_cp = '0;
        s1      = state;
        p       = ltc_pkg::plain(char_code);

        // character phase: slot 0 pending/digraph, slot 1 plain character
        if (state == ltc_pkg::ST_ERR)
        begin
            s1 = ltc_pkg::ST_ERR;
        end
        else if (state == ltc_pkg::ST_C)
        begin
            if (char_code == ltc_pkg::CH_H)
            begin
                cand_v[0]  = 1'b1;
                cand_cp[0] = ltc_pkg::CP_CHE;
                s1         = ltc_pkg::ST_IDLE;
            end
            else
            begin
                s1 = ltc_pkg::ST_ERR;
            end
        end
        else if (state == ltc_pkg::ST_SHC)
        begin
            cand_v[0] = 1'b1;
            if (char_code == ltc_pkg::CH_H)
            begin
                cand_cp[0] = ltc_pkg::CP_SHCHA;
                s1         = ltc_pkg::ST_IDLE;
            end
            else
            begin
                cand_cp[0] = ltc_pkg::CP_SHA;
                s1         = ltc_pkg::ST_ERR;
            end
        end
        else if (ltc_pkg::pending_cp(state) != 11'h000)
        begin
            s1        = ltc_pkg::ST_IDLE;
            cand_v[0] = 1'b1;
            if (state == ltc_pkg::ST_Y && char_code == ltc_pkg::CH_A)
                cand_cp[0] = ltc_pkg::CP_YA;
            else if (state == ltc_pkg::ST_Y && char_code == ltc_pkg::CH_E)
                cand_cp[0] = ltc_pkg::CP_YE;
            else if (state == ltc_pkg::ST_Y && char_code == ltc_pkg::CH_O)
                cand_cp[0] = ltc_pkg::CP_YO;
            else if (state == ltc_pkg::ST_Y && char_code == ltc_pkg::CH_U)
                cand_cp[0] = ltc_pkg::CP_YU;
            else if (state == ltc_pkg::ST_Z && char_code == ltc_pkg::CH_H)
                cand_cp[0] = ltc_pkg::CP_ZHE;
            else if (state == ltc_pkg::ST_S && char_code == ltc_pkg::CH_H)
            begin
                cand_v[0] = 1'b0;
                s1        = ltc_pkg::ST_SH;
            end
            else if (state == ltc_pkg::ST_K && char_code == ltc_pkg::CH_H)
                cand_cp[0] = ltc_pkg::CP_KHA;
            else if (state == ltc_pkg::ST_T && char_code == ltc_pkg::CH_S)
                cand_cp[0] = ltc_pkg::CP_TSE;
            else if (state == ltc_pkg::ST_SH && char_code == ltc_pkg::CH_C)
            begin
                cand_v[0] = 1'b0;
                s1        = ltc_pkg::ST_SHC;
            end
            else
            begin
                cand_cp[0] = ltc_pkg::pending_cp(state);
                cand_v[1]  = p.emit;
                cand_cp[1] = p.cp;
                s1         = p.next_state;
            end
        end
        else
        begin
            cand_v[1]  = p.emit;
            cand_cp[1] = p.cp;
            s1         = p.next_state;
        end

        // end of word
        if (last_char)
        begin
            if (s1 == ltc_pkg::ST_C || s1 == ltc_pkg::ST_SHC)
            begin
                s1 = ltc_pkg::ST_ERR;
            end
            else if (s1 != ltc_pkg::ST_ERR && ltc_pkg::pending_cp(s1) != 11'h000)
            begin
                cand_v[2]  = 1'b1;
                cand_cp[2] = ltc_pkg::pending_cp(s1);
            end
            cand_v[3] = (s1 == ltc_pkg::ST_ERR);
            cand_k[3] = ltc_pkg::KIND_ERR;
            cand_v[4] = 1'b1;
            cand_k[4] = ltc_pkg::KIND_EOL;
            s1        = ltc_pkg::ST_IDLE;
        end

        // pack the candidates in order
        step.res = '0;
        n        = 3'd0;
        for (int i = 0; i < 5; i++)
        begin
            if (cand_v[i] && n < 3'd3)
            begin
                step.res[n[1:0]].kind = cand_k[i];
                step.res[n[1:0]].cp   = cand_cp[i];
                n                     = n + 3'd1;
            end
        end
        step.cnt        = n[1:0];
        step.next_state = s1;
    end

endmodule

FILE: hdl/ltc_resbuf.sv
// Result buffer: holds the up to three results of one item and drains them in order.
// Depends on ltc_pkg and ltc_out_if.
`timescale 1ns / 1ps

module ltc_resbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ltc_pkg::step_t    step,
    output logic              free,
    ltc_out_if.source         results
);

    ltc_pkg::res_t [2:0] ent_reg;
    logic [1:0]          cnt_reg;
    logic [1:0]          idx_reg;
    logic                last_out;

    assign last_out = (cnt_reg != 2'd0) && (idx_reg == cnt_reg - 2'd1);
    assign free     = (cnt_reg == 2'd0) || (results.ready && last_out);

    assign results.valid      = (cnt_reg != 2'd0);
    assign results.kind       = ent_reg[idx_reg].kind;
    assign results.code_point = ent_reg[idx_reg].cp;
    assign results.run_end    = last_out;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= step.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= step.cnt;
            idx_reg <= 2'd0;
        end
        else if (results.valid && results.ready)
        begin
            if (last_out)
            begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result buffer overwritten");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (idx_reg < cnt_reg))
        else $error("read index past fill count");

    a_eol_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.kind == ltc_pkg::KIND_EOL) |-> results.run_end)
        else $error("end of line not last result");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (load && step.cnt != 2'd0) |=> results.valid)
        else $error("loaded results not presented");

endmodule

FILE: hdl/latin_to_cyrillic_transliterator.sv
// Latin to Cyrillic transliterator, top level: input register, digraph state, result buffer.
// Depends on ltc_pkg, ltc_in_if, ltc_out_if, ltc_step and ltc_resbuf.
//
// Usage:
//   chars   - one ASCII character per item (char_code), last_char marks the end of a word.
//   results - one item per emitted symbol: kind (character, error marker, end of line),
//             code_point (zero for markers) and run_end on the last result of an input item.
//   Each input item gives zero to three results. The end of a word always gives an
//   end-of-line result, preceded by an error marker when the word held an illegal sequence.
// Path: the item is registered in the input register, its results then in the result buffer.
// Throughput: one result per cycle while results.ready is high; an input item is taken every
//   cycle if each gives at most one result; else the next waits until the last result is taken.
//   The rate is set by the single read port of the three-entry result buffer.
// Reset: the digraph state returns to idle and both registers are emptied.
// Stall: while results.ready is low the current result holds; items that give no result
//   still pass, the first one with results waits in the input register and chars.ready drops.
`timescale 1ns / 1ps

module latin_to_cyrillic_transliterator (
    input  logic      clk,
    input  logic      rst_n,
    ltc_in_if.sink    chars,
    ltc_out_if.source results
);

    logic           in_valid_reg;
    logic [6:0]     char_reg;
    logic           last_reg;
    logic [3:0]     state_reg;
    logic           advance;
    logic           buf_free;
    ltc_pkg::step_t step;

    ltc_step u_step (
        .state     (state_reg),
        .char_code (char_reg),
        .last_char (last_reg),
        .step      (step)
    );

    ltc_resbuf u_resbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance && (step.cnt != 2'd0)),
        .step    (step),
        .free    (buf_free),
        .results (results)
    );

    assign advance     = in_valid_reg && ((step.cnt == 2'd0) || buf_free);
    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.char_code;
            last_reg <= chars.last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= ltc_pkg::ST_IDLE;
        end
        else
        begin
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end
            if (advance)
            begin
                state_reg <= step.next_state;
            end
        end
    end

endmodule
